### src/l2srgb_pkg.sv
// shared constants, threshold tables and search step for the srgb byte encoder
package l2srgb_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned VALUE_W   = 24;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned Q32_SHIFT = 32 - FRAC_BITS;
	localparam int unsigned QNT_SHIFT = FRAC_BITS - BYTE_W;
	localparam int unsigned LIN_N     = 15;
	localparam int unsigned POW_N     = 256;

	// register select bit of paddr
	localparam logic REG_CH_COUNT = 1'b0;
	localparam logic REG_CONVERT  = 1'b1;

	localparam logic [2:0] CH_COUNT_RST = 3'd4;
	localparam logic       CONVERT_RST  = 1'b1;
	localparam logic [2:0] CONV_CH_MAX  = 3'd3;

	typedef logic [31:0] q32_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef q32_t pow_tbl_t [POW_N];
	typedef q32_t lin_tbl_t [LIN_N];

	// largest v in q0.32 that stays on the linear segment
	localparam logic [63:0] LIN_MAX_V = (64'd31308 << 32) / 64'd10000000;

	// v in q0.32 at which 12.92 * 256 * v reaches j + 1, rounded up
	function automatic lin_tbl_t build_lin_tbl();
		lin_tbl_t t;
		logic [63:0] num;
		for (int j = 0; j < LIN_N; j++) begin
			num = (64'(j + 1) * 64'd100) << 32;
			t[j] = 32'((num + 64'd330751) / 64'd330752);
		end
		return t;
	endfunction

	// q0.32 lower bound of code k on the power segment
	function automatic q32_t pow_threshold(input logic [63:0] k);
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] r;
		logic [63:0] cand;
		logic [63:0] r2;
		logic [63:0] p;
		y  = ((64'd25 * k + 64'd352) << 32) / 64'd6752;
		y2 = (y * y) >> 32;
		r  = 64'd0;
		for (int b = 31; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			r2   = (cand * cand) >> 32;
			p    = (((r2 * r2) >> 32) * cand) >> 32;
			if (p <= y2) begin
				r = cand;
			end
		end
		return 32'((y2 * r) >> 32);
	endfunction

	function automatic pow_tbl_t build_pow_tbl();
		pow_tbl_t t;
		t[0] = '0;
		for (int k = 1; k < POW_N; k++) begin
			t[k] = pow_threshold(64'(k));
		end
		return t;
	endfunction

	localparam lin_tbl_t LIN_TBL = build_lin_tbl();
	localparam pow_tbl_t POW_TBL = build_pow_tbl();

	// one bit of the binary search for the largest code whose threshold v reaches
	function automatic byte_t pow_step(input q32_t v, input byte_t k, input int unsigned b);
		byte_t cand;
		cand = k | (byte_t'(1) << b);
		return (v >= POW_TBL[cand]) ? cand : k;
	endfunction

endpackage

### src/linear_to_srgb_byte_encode_core.sv
// an accepted sample beat passes the registered stages s1 to s5 before its byte beat
// throughput: one beat per cycle while byte_stall is low, the threshold search takes two bits in each of four stages
// each stage holds while its successor is full and stalled, bubbles are squeezed out
// reset: pipeline empty, channel_count = 4, convert_enable = 1
// top level of the linear to srgb byte encoder
module linear_to_srgb_byte_encode_core
	import l2srgb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [23:0] linear_value,
	input  logic [1:0]         channel_index,
	output logic               byte_valid,
	input  logic               byte_stall,
	output logic [7:0]         pixel_byte
);

	logic [2:0] ch_count_q;
	logic       convert_q;

	logic wr_en;
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_count_q <= CH_COUNT_RST;
			convert_q  <= CONVERT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_CH_COUNT: ch_count_q <= pwdata[2:0];
				REG_CONVERT:  convert_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CH_COUNT: prdata = {29'd0, ch_count_q};
			REG_CONVERT:  prdata = {31'd0, convert_q};
			default:      prdata = '0;
		endcase
	end

	// input decode
	logic [VALUE_W-1:0] raw;
	logic [2:0]         conv_limit;
	logic               in_neg;
	logic               in_zero;
	logic               in_full;
	logic               in_conv;
	q32_t               v_in;
	logic [VALUE_W-1:0] quant;
	logic               in_lin;

	assign raw        = $unsigned(linear_value);
	assign conv_limit = (ch_count_q < CONV_CH_MAX) ? ch_count_q : CONV_CH_MAX;
	assign in_neg     = raw[VALUE_W-1];
	assign in_zero    = (raw == '0);
	assign in_full    = ({1'b0, raw} >= ((VALUE_W+1)'(1) << FRAC_BITS));
	assign in_conv    = convert_q && ({1'b0, channel_index} < conv_limit);
	assign v_in       = 32'({{(32-VALUE_W){1'b0}}, raw} << Q32_SHIFT);
	assign quant      = raw >> QNT_SHIFT;
	assign in_lin     = ({32'd0, v_in} <= LIN_MAX_V);

	// stage enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = !vld_s5 || !byte_stall;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign sample_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= sample_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// payload
	q32_t        v_s1, v_s2, v_s3, v_s4;
	logic        pow_s1, pow_s2, pow_s3, pow_s4;
	logic        lin_s1, lin_s2;
	byte_t       fix_s1, fix_s2, fix_s3, fix_s4;
	logic [LIN_N-1:0] linhit_s2;
	byte_t       k_s2, k_s3, k_s4;
	byte_t       byte_s5;
	logic [LIN_N-1:0] linhit;

	always_comb begin
		for (int j = 0; j < LIN_N; j++) begin
			linhit[j] = (v_s1 >= LIN_TBL[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			v_s1   <= v_in;
			pow_s1 <= !in_neg && !in_zero && !in_full && in_conv && !in_lin;
			lin_s1 <= !in_neg && !in_zero && !in_full && in_conv && in_lin;
			if (in_neg || in_zero) begin
				fix_s1 <= '0;
			end else if (in_full) begin
				fix_s1 <= '1;
			end else begin
				fix_s1 <= quant[BYTE_W-1:0];
			end
		end
		if (en_s2) begin
			v_s2      <= v_s1;
			pow_s2    <= pow_s1;
			lin_s2    <= lin_s1;
			fix_s2    <= fix_s1;
			linhit_s2 <= linhit;
			k_s2      <= pow_step(v_s1, pow_step(v_s1, '0, 7), 6);
		end
		if (en_s3) begin
			v_s3   <= v_s2;
			pow_s3 <= pow_s2;
			fix_s3 <= lin_s2 ? byte_t'($countones(linhit_s2)) : fix_s2;
			k_s3   <= pow_step(v_s2, pow_step(v_s2, k_s2, 5), 4);
		end
		if (en_s4) begin
			v_s4   <= v_s3;
			pow_s4 <= pow_s3;
			fix_s4 <= fix_s3;
			k_s4   <= pow_step(v_s3, pow_step(v_s3, k_s3, 3), 2);
		end
		if (en_s5) begin
			byte_s5 <= pow_s4 ? pow_step(v_s4, pow_step(v_s4, k_s4, 1), 0) : fix_s4;
		end
	end

	assign byte_valid = vld_s5;
	assign pixel_byte = byte_s5;

endmodule

### bench/tb_linear_to_srgb_byte_encode_core.sv
// self-checking bench for the linear to srgb byte encoder: directed and random samples
module tb_linear_to_srgb_byte_encode_core;
	import l2srgb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ADDR_CH_COUNT = {REG_CH_COUNT, 2'b00};
	localparam logic [2:0] ADDR_CONVERT  = {REG_CONVERT, 2'b00};
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 190;
	localparam int SETTLE_TICKS = 10;

	typedef struct {
		logic [23:0] value;
		logic [1:0]  chan;
	} sample_t;

	typedef struct {
		logic [7:0]  code;
		logic [23:0] value;
		logic [1:0]  chan;
	} byte_expect_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	logic signed [23:0] linear_value = '0;
	logic [1:0]  channel_index = '0;
	logic        byte_valid;
	logic        byte_stall = 1'b0;
	logic [7:0]  pixel_byte;

	sample_t      pending_samples [$];
	byte_expect_t expected_bytes [$];
	logic [63:0]  pow_lower [POW_N];
	logic [2:0]   cfg_count = CH_COUNT_RST;
	logic         cfg_convert = CONVERT_RST;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           send_gap = 0;
	int           stall_left = 0;
	int           errors = 0;
	int           samples_sent = 0;
	int           bytes_checked = 0;
	int           settings_seen = 1;

	linear_to_srgb_byte_encode_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.linear_value  (linear_value),
		.channel_index (channel_index),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.pixel_byte    (pixel_byte)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// q0.32 lower bound of code k on the curved segment
	function automatic logic [63:0] curve_lower(input logic [63:0] k);
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] root;
		logic [63:0] trial;
		logic [63:0] sq;
		logic [63:0] fifth;
		y    = ((64'd25 * k + 64'd352) << 32) / 64'd6752;
		y2   = (y * y) >> 32;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			sq    = (trial * trial) >> 32;
			fifth = (((sq * sq) >> 32) * trial) >> 32;
			if (fifth <= y2) begin
				root = trial;
			end
		end
		return (y2 * root) >> 32;
	endfunction

	function automatic logic [7:0] srgb_byte(input logic [23:0] raw, input logic [1:0] chan);
		logic [63:0] v;
		logic [7:0]  k;
		logic [7:0]  trial;
		logic [2:0]  limit;
		limit = (cfg_count < CONV_CH_MAX) ? cfg_count : CONV_CH_MAX;
		if (raw[23] || raw == '0) begin
			return 8'd0;
		end
		if (raw >= 24'h010000) begin
			return 8'd255;
		end
		if (!(cfg_convert && {1'b0, chan} < limit)) begin
			return raw[15:8];
		end
		v = 64'(raw[15:0]) << 16;
		if (v * 64'd10000000 <= (64'd31308 << 32)) begin
			return 8'(((v * 64'd330752) / 64'd100) >> 32);
		end
		k = '0;
		for (int b = 7; b >= 0; b--) begin
			trial = k | (8'd1 << b);
			if (v >= pow_lower[trial]) begin
				k = trial;
			end
		end
		return k;
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		case ($urandom_range(0, 9))
			0: s.value = 24'($urandom);
			1: s.value = {1'b1, 23'($urandom)};
			2: s.value = 24'($urandom_range(180, 230));
			3: s.value = 24'($urandom_range(65500, 65536));
			4: s.value = 24'($urandom_range(1, 255));
			default: s.value = 24'($urandom_range(1, 65535));
		endcase
		s.chan = 2'($urandom_range(0, 3));
		return s;
	endfunction

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || !sample_stall) begin
			if (send_gap > 0) begin
				send_gap     <= send_gap - 1;
				sample_valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				if ($urandom_range(0, 99) < send_idle_pct) begin
					send_gap     <= $urandom_range(1, 13) - 1;
					sample_valid <= 1'b0;
				end else begin
					linear_value  <= pending_samples[0].value;
					channel_index <= pending_samples[0].chan;
					sample_valid  <= 1'b1;
					void'(pending_samples.pop_front());
				end
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			byte_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < recv_idle_pct) begin
			stall_left <= $urandom_range(1, 13) - 1;
			byte_stall <= 1'b1;
		end else begin
			byte_stall <= 1'b0;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		byte_expect_t e;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				e.value = linear_value;
				e.chan  = channel_index;
				e.code  = srgb_byte(linear_value, channel_index);
				expected_bytes.push_back(e);
				samples_sent++;
			end
			if (byte_valid && !byte_stall) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: byte beat %0d with nothing outstanding", $time, pixel_byte);
					errors++;
				end else begin
					e = expected_bytes.pop_front();
					bytes_checked++;
					if (pixel_byte !== e.code) begin
						$display("%0t: pixel_byte expected %0d, actual %0d (value 0x%06h, channel %0d)",
							$time, e.code, pixel_byte, e.value, e.chan);
						errors++;
					end
				end
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
			output logic [31:0] rd);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic [2:0] count, input logic conv);
		logic [31:0] rd;
		apb_access(1'b1, ADDR_CH_COUNT, {29'($urandom), count}, rd);
		cfg_count = count;
		apb_access(1'b1, ADDR_CONVERT, {31'($urandom), conv}, rd);
		cfg_convert = conv;
		apb_access(1'b0, ADDR_CH_COUNT, '0, rd);
		if (rd[2:0] !== cfg_count) begin
			$display("%0t: channel_count readback expected %0d, actual %0d", $time, cfg_count, rd[2:0]);
			errors++;
		end
		apb_access(1'b0, ADDR_CONVERT, '0, rd);
		if (rd[0] !== cfg_convert) begin
			$display("%0t: convert_enable readback expected %0d, actual %0d", $time, cfg_convert, rd[0]);
			errors++;
		end
		settings_seen++;
	endtask

	// sampled at the falling edge so a beat still waiting on the input is seen
	task automatic drain();
		@(negedge clk);
		while (pending_samples.size() != 0 || sample_valid || expected_bytes.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic push_sample(input logic [23:0] value, input logic [1:0] chan);
		sample_t s;
		s.value = value;
		s.chan  = chan;
		pending_samples.push_back(s);
	endtask

	initial begin
		logic [2:0] phase_count [PHASES];
		logic       phase_conv [PHASES];
		int         phase_send [PHASES];
		int         phase_recv [PHASES];
		phase_count = '{3'd3, 3'd0, 3'd7, 3'd1, 3'd2, 3'd5, 3'd6, 3'd4};
		phase_conv  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		phase_send  = '{20, 0, 35, 10, 50, 15, 0, 0};
		phase_recv  = '{20, 0, 10, 40, 50, 25, 0, 0};
		pow_lower[0] = '0;
		for (int k = 1; k < POW_N; k++) begin
			pow_lower[k] = curve_lower(64'(k));
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: channels 0..2 converted, channel 3 quantized
		push_sample(24'h000000, 2'd0);
		push_sample(24'h000001, 2'd0);
		push_sample(24'h0000CC, 2'd1);
		push_sample(24'h0000CD, 2'd2);
		push_sample(24'h0000CE, 2'd0);
		push_sample(24'h0000FF, 2'd1);
		push_sample(24'h000100, 2'd2);
		push_sample(24'h008000, 2'd0);
		push_sample(24'h00FFFF, 2'd1);
		push_sample(24'h00FFFE, 2'd2);
		push_sample(24'h010000, 2'd0);
		push_sample(24'h7FFFFF, 2'd1);
		push_sample(24'hFFFFFF, 2'd2);
		push_sample(24'h800000, 2'd0);
		push_sample(24'h000001, 2'd3);
		push_sample(24'h0000CD, 2'd3);
		push_sample(24'h008000, 2'd3);
		push_sample(24'h00FFFF, 2'd3);
		push_sample(24'h7FFFFF, 2'd3);
		push_sample(24'h800000, 2'd3);
		push_sample(24'h004000, 2'd1);
		push_sample(24'h000800, 2'd2);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			set_config(phase_count[p], phase_conv[p]);
			send_idle_pct = phase_send[p];
			recv_idle_pct = phase_recv[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pending_samples.push_back(random_sample());
			end
			// wait until every byte of this setting is back before the next setting
			drain();
		end

		$display("samples %0d, bytes checked %0d, register settings %0d",
			samples_sent, bytes_checked, settings_seen);
		$display("settings spanned channel_count 0..7 with encoding on and off, stalls on both sides");
		if (errors == 0) begin
			$display("tb_linear_to_srgb_byte_encode_core: done, clean");
		end else begin
			$display("tb_linear_to_srgb_byte_encode_core: done, errors");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout with %0d bytes outstanding", expected_bytes.size());
		$display("tb_linear_to_srgb_byte_encode_core: done, errors");
		$finish;
	end

endmodule

### linear_to_srgb_byte_encode_core.f
src/l2srgb_pkg.sv
src/linear_to_srgb_byte_encode_core.sv
bench/tb_linear_to_srgb_byte_encode_core.sv
